### hw/rtl/bpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

  // granted offset width is fixed by the result format
  localparam int OFF_W = 13;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_NOFIT = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_ASCAN = 9'b000000100,
    S_AMARK = 9'b000001000,
    S_FFIND = 9'b000010000,
    S_FREAD = 9'b000100000,
    S_FLEN  = 9'b001000000,
    S_FCLR  = 9'b010000000,
    S_RESP  = 9'b100000000
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/block_pool_allocator.sv
// channel | handshake               | payload
// --------+-------------------------+----------------------------------------
// in      | in_valid / in_stall     | kind, request_bytes, release_offset
// out     | out_valid / out_stall   | status, granted_offset
//
// allocate: zero size answers straight from S_RESP; otherwise, an oversized request too, the map
//   is scanned top down one entry a cycle and the run is then marked one entry a cycle,
//   as the map memory has a single write and a single read port
// free: outside the pool answers straight from S_RESP; otherwise the entry is located (S_FFIND),
//   read (S_FREAD) and its length taken (S_FLEN), then a nonzero run is cleared one entry a cycle
// reset: a clearing pass over all NUM_BLOCKS entries with in_stall high
// one item in flight; a pending result does not hold off the next beat
`timescale 1ns / 1ps
`default_nettype none

module block_pool_allocator #(
  parameter int NUM_BLOCKS  = 256,
  parameter int BLOCK_BYTES = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       kind,
  input  wire logic [31:0]                request_bytes,
  input  wire logic [31:0]                release_offset,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [1:0]                      status,
  output logic [bpa_pkg::OFF_W-1:0]       granted_offset
);

  localparam int AW   = $clog2(NUM_BLOCKS);
  localparam int LW   = $clog2(NUM_BLOCKS + 1);
  localparam int RB_W = $clog2(NUM_BLOCKS * BLOCK_BYTES + 1);
  localparam logic [31:0]   POOL_BYTES = 32'(NUM_BLOCKS * BLOCK_BYTES);
  localparam logic [RB_W-1:0] BB_R     = RB_W'(BLOCK_BYTES);
  localparam logic [AW-1:0] LAST_BLK   = AW'(NUM_BLOCKS - 1);

  // offset / BLOCK_BYTES by reciprocal multiply, exact for every offset in the pool
  localparam int DIV_N = $clog2(NUM_BLOCKS * BLOCK_BYTES);
  localparam int DIV_L = $clog2(BLOCK_BYTES);
  localparam int DIV_S = DIV_N + DIV_L;
  localparam int MUL_W = 2 * DIV_N + 2;
  localparam logic [63:0] DIV_M =
    ((64'd1 << DIV_S) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);

  bpa_pkg::state_t  state;
  bpa_pkg::status_t res_status;
  logic [bpa_pkg::OFF_W-1:0] res_offset;
  logic [31:0]      req;

  logic [AW-1:0]    scan_addr;
  logic             scan_done;
  logic [AW-1:0]    data_addr;
  logic             data_vld;
  logic [LW-1:0]    run;
  logic [RB_W-1:0]  run_bytes;

  logic [AW-1:0]    mark_addr;
  logic [LW-1:0]    mark_cnt;
  logic [LW-1:0]    mark_len;

  logic [AW-1:0]    idx;
  logic [AW-1:0]    clr_addr;
  logic [LW-1:0]    clr_cnt;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [LW-1:0]    ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [LW-1:0]    rd_data;

  logic             accept;
  logic             push;
  logic             entry_free;
  logic [LW-1:0]    run_next;
  logic [RB_W-1:0]  run_bytes_next;
  logic             hit;
  logic [MUL_W-1:0] div_prod;
  logic [31:0]      prod;

  bpa_ram #(
    .WIDTH(LW),
    .DEPTH(NUM_BLOCKS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rd_data)
  );

  assign in_stall = (state != bpa_pkg::S_IDLE);
  assign accept   = in_valid && (state == bpa_pkg::S_IDLE);
  assign push     = (state == bpa_pkg::S_RESP) && (!out_valid || !out_stall);

  assign ram_we    = (state == bpa_pkg::S_CLEAR) || (state == bpa_pkg::S_AMARK) ||
                     (state == bpa_pkg::S_FCLR);
  assign ram_waddr = (state == bpa_pkg::S_AMARK) ? mark_addr : clr_addr;
  assign ram_wdata = (state == bpa_pkg::S_AMARK) ? mark_len : '0;
  assign ram_raddr = (state == bpa_pkg::S_ASCAN) ? scan_addr : idx;

  // run measured in bytes, so the first hit is exactly the rounded-up length
  assign entry_free     = (rd_data == '0);
  assign run_next       = entry_free ? LW'(run + 1'b1) : '0;
  assign run_bytes_next = entry_free ? RB_W'(run_bytes + BB_R) : '0;
  assign hit            = data_vld && entry_free && (32'(run_bytes_next) >= req);
  assign div_prod       = MUL_W'(req[DIV_N-1:0]) * MUL_W'(DIV_M);
  assign prod           = 32'(data_addr) * 32'(BLOCK_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpa_pkg::S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !push) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        bpa_pkg::S_CLEAR: begin
          if (clr_addr == LAST_BLK) begin
            state <= bpa_pkg::S_IDLE;
          end else begin
            clr_addr <= AW'(clr_addr + 1'b1);
          end
        end
        bpa_pkg::S_IDLE: begin
          if (accept) begin
            if (kind == bpa_pkg::KIND_FREE) begin
              state <= (release_offset >= POOL_BYTES) ? bpa_pkg::S_RESP : bpa_pkg::S_FFIND;
            end else begin
              state <= (request_bytes == '0) ? bpa_pkg::S_RESP : bpa_pkg::S_ASCAN;
            end
          end
        end
        bpa_pkg::S_ASCAN: begin
          if (hit) begin
            state <= bpa_pkg::S_AMARK;
          end else if (data_vld && data_addr == '0) begin
            state <= bpa_pkg::S_RESP;
          end
        end
        bpa_pkg::S_AMARK: begin
          if (mark_cnt == LW'(1)) begin
            state <= bpa_pkg::S_RESP;
          end
        end
        bpa_pkg::S_FFIND: begin
          state <= bpa_pkg::S_FREAD;
        end
        bpa_pkg::S_FREAD: begin
          state <= bpa_pkg::S_FLEN;
        end
        bpa_pkg::S_FLEN: begin
          if (rd_data == '0) begin
            state <= bpa_pkg::S_RESP;
          end else begin
            state    <= bpa_pkg::S_FCLR;
            clr_addr <= idx;
          end
        end
        bpa_pkg::S_FCLR: begin
          // clearing stops at the top of the map
          if (clr_cnt == LW'(1) || clr_addr == LAST_BLK) begin
            state <= bpa_pkg::S_RESP;
          end else begin
            clr_addr <= AW'(clr_addr + 1'b1);
          end
        end
        bpa_pkg::S_RESP: begin
          if (push) begin
            out_valid <= 1'b1;
            state     <= bpa_pkg::S_IDLE;
          end
        end
        default: begin
          state <= bpa_pkg::S_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req        <= (kind == bpa_pkg::KIND_FREE) ? release_offset : request_bytes;
      res_offset <= '0;
      if (kind == bpa_pkg::KIND_FREE) begin
        res_status <= (release_offset >= POOL_BYTES) ? bpa_pkg::ST_RANGE : bpa_pkg::ST_OK;
      end else if (request_bytes == '0) begin
        res_status <= bpa_pkg::ST_ZERO;
      end else begin
        res_status <= bpa_pkg::ST_NOFIT;
      end
      scan_addr <= LAST_BLK;
      scan_done <= 1'b0;
      data_vld  <= 1'b0;
      run       <= '0;
      run_bytes <= '0;
      idx       <= '0;
    end

    if (state == bpa_pkg::S_ASCAN) begin
      // each read issues in the cycle before its entry is judged
      data_addr <= scan_addr;
      data_vld  <= !scan_done;
      if (scan_addr == '0) begin
        scan_done <= 1'b1;
      end else begin
        scan_addr <= AW'(scan_addr - 1'b1);
      end
      if (data_vld) begin
        run       <= run_next;
        run_bytes <= run_bytes_next;
      end
      if (hit) begin
        res_status <= bpa_pkg::ST_OK;
        res_offset <= prod[bpa_pkg::OFF_W-1:0];
        mark_addr  <= data_addr;
        mark_cnt   <= run_next;
        mark_len   <= run_next;
      end
    end

    if (state == bpa_pkg::S_AMARK) begin
      mark_addr <= AW'(mark_addr + 1'b1);
      mark_cnt  <= LW'(mark_cnt - 1'b1);
    end

    if (state == bpa_pkg::S_FFIND) begin
      idx <= AW'(div_prod >> DIV_S);
    end

    if (state == bpa_pkg::S_FLEN) begin
      clr_cnt <= rd_data;
    end

    if (state == bpa_pkg::S_FCLR) begin
      clr_cnt <= LW'(clr_cnt - 1'b1);
    end

    if (push) begin
      status         <= res_status;
      granted_offset <= res_offset;
    end
  end

  a_offset_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && granted_offset != '0) |-> (status == bpa_pkg::ST_OK))
    else $error("nonzero granted offset on a failed beat");

  a_mark_in_map: assert property (@(posedge clk) disable iff (rst)
    (state == bpa_pkg::S_AMARK) |->
      ((32'(mark_addr) + 32'(mark_cnt)) <= 32'(NUM_BLOCKS)))
    else $error("run marking runs past the top of the map");

  a_mark_ends_ok: assert property (@(posedge clk) disable iff (rst)
    (state == bpa_pkg::S_AMARK && mark_cnt == LW'(1)) |=>
      (state == bpa_pkg::S_RESP && res_status == bpa_pkg::ST_OK))
    else $error("finished marking without an ok result");

  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == bpa_pkg::S_CLEAR && state == bpa_pkg::S_IDLE) |->
      ($past(clr_addr) == LAST_BLK))
    else $error("left the clearing pass early");

endmodule

`default_nettype wire

### hw/rtl/bpa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bpa_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
